// ----- rtl/bslr_pkg.sv -----
package bslr_pkg;

   // field widths
   localparam int COORD_W     = 6;
   localparam int SIZE_W      = 7;
   localparam int RAD_W       = 4;
   localparam int ERR_W       = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BRUSH_RADIUS = 2'd2;

   // register reset values
   localparam logic [SIZE_W-1:0] GRID_SIZE_RESET    = 7'd64;
   localparam logic [RAD_W-1:0]  BRUSH_RADIUS_RESET = 4'd1;

   // controller to datapath
   typedef struct packed {
      logic load;   // pressed sample taken: set up a new line
      logic lift;   // released sample taken: pen up
      logic emit;   // register current point into the output slot and step
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic at_target;  // current point is the line end
      logic at_cap;     // current point is the last one allowed
   } dp_sts_type;

endpackage

// ----- rtl/bslr_ctrl.sv -----
module bslr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_pressed,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  bslr_pkg::dp_sts_type   sts,
   output bslr_pkg::dp_cmd_type   cmd
);
   import bslr_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign slot_free  = ~rsp_valid_ff | rsp_tready;

   assign cmd.load = accept & req_pressed;
   assign cmd.lift = accept & ~req_pressed;
   assign cmd.emit = (state_ff == ST_WALK) & slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (cmd.emit && (sts.at_target || sts.at_cap)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/bslr_datapath.sv -----
module bslr_datapath #(
   parameter int GRID_MAX = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bslr_pkg::dp_cmd_type                 cmd,
   output bslr_pkg::dp_sts_type                 sts,
   input  logic                                 csr_write,
   input  logic [bslr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bslr_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic [bslr_pkg::COORD_W-1:0]         req_col,
   input  logic [bslr_pkg::COORD_W-1:0]         req_row,
   output logic [bslr_pkg::COORD_W-1:0]         point_col,
   output logic [bslr_pkg::COORD_W-1:0]         point_row,
   output logic [bslr_pkg::COORD_W-1:0]         col_lo,
   output logic [bslr_pkg::COORD_W-1:0]         col_hi,
   output logic [bslr_pkg::COORD_W-1:0]         row_lo,
   output logic [bslr_pkg::COORD_W-1:0]         row_hi,
   output logic                                 last_point
);
   import bslr_pkg::*;

   localparam int CNT_W = $clog2(GRID_MAX);
   localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(GRID_MAX);
   localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(GRID_MAX - 1);

   // configuration
   logic [SIZE_W-1:0] grid_cols_ff, grid_rows_ff;
   logic [RAD_W-1:0]  brush_radius_ff;

   // stroke state
   logic               pen_down_ff;
   logic [COORD_W-1:0] prev_col_ff, prev_row_ff;

   // line walk
   logic [COORD_W-1:0]     x_ff, y_ff, tc_ff, tr_ff;
   logic                   x_neg_ff, y_neg_ff;
   logic signed [ERR_W-1:0] dx_ff, dy_ff, err_ff;
   logic [CNT_W-1:0]       cnt_ff;

   // output slot
   logic [COORD_W-1:0] point_col_ff, point_row_ff;
   logic [COORD_W-1:0] col_lo_ff, col_hi_ff, row_lo_ff, row_hi_ff;
   logic               last_point_ff;

   logic [SIZE_W-1:0] ncols_m1, nrows_m1;
   logic [COORD_W-1:0] tc_in, tr_in, x0, y0;
   logic signed [COORD_W+1:0] col_diff, row_diff;
   logic [COORD_W+1:0] col_abs, row_abs;
   logic signed [ERR_W-1:0] dx_in, dy_in;
   logic signed [ERR_W:0]   e2;
   logic step_x, step_y;
   logic [SIZE_W-1:0] x_ext, y_ext, rad_ext, chi_sum, rhi_sum;

   function automatic logic [SIZE_W-1:0] size_m1(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] s;
      if (v == '0) s = SIZE_W'(1);
      else if (v > SIZE_MAX) s = SIZE_MAX;
      else s = v;
      return s - SIZE_W'(1);
   endfunction

   assign ncols_m1 = size_m1(grid_cols_ff);
   assign nrows_m1 = size_m1(grid_rows_ff);

   // pointer clamped to the grid in use
   assign tc_in = ({1'b0, req_col} > ncols_m1) ? ncols_m1[COORD_W-1:0] : req_col;
   assign tr_in = ({1'b0, req_row} > nrows_m1) ? nrows_m1[COORD_W-1:0] : req_row;
   assign x0 = pen_down_ff ? prev_col_ff : tc_in;
   assign y0 = pen_down_ff ? prev_row_ff : tr_in;

   assign col_diff = $signed({2'b00, tc_in}) - $signed({2'b00, x0});
   assign row_diff = $signed({2'b00, tr_in}) - $signed({2'b00, y0});
   assign col_abs  = col_diff[COORD_W+1] ? $unsigned(-col_diff) : $unsigned(col_diff);
   assign row_abs  = row_diff[COORD_W+1] ? $unsigned(-row_diff) : $unsigned(row_diff);
   assign dx_in    = ERR_W'(col_abs);
   assign dy_in    = -ERR_W'(row_abs);

   // bresenham decision
   assign e2     = {err_ff, 1'b0};
   assign step_x = e2 >= (ERR_W+1)'(dy_ff);
   assign step_y = e2 <= (ERR_W+1)'(dx_ff);

   assign sts.at_target = (x_ff == tc_ff) && (y_ff == tr_ff);
   assign sts.at_cap    = (cnt_ff == CNT_LAST);

   // brush rectangle
   assign x_ext   = SIZE_W'(x_ff);
   assign y_ext   = SIZE_W'(y_ff);
   assign rad_ext = SIZE_W'(brush_radius_ff);
   assign chi_sum = x_ext + rad_ext;
   assign rhi_sum = y_ext + rad_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff    <= GRID_SIZE_RESET;
         grid_rows_ff    <= GRID_SIZE_RESET;
         brush_radius_ff <= BRUSH_RADIUS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GRID_COLS:    grid_cols_ff    <= csr_data;
            CSR_GRID_ROWS:    grid_rows_ff    <= csr_data;
            CSR_BRUSH_RADIUS: brush_radius_ff <= csr_data[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_down_ff <= 1'b0;
         prev_col_ff <= '0;
         prev_row_ff <= '0;
      end else if (cmd.load) begin
         pen_down_ff <= 1'b1;
         prev_col_ff <= tc_in;
         prev_row_ff <= tr_in;
      end else if (cmd.lift) begin
         pen_down_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= x0;
         y_ff     <= y0;
         tc_ff    <= tc_in;
         tr_ff    <= tr_in;
         x_neg_ff <= ~(x0 < tc_in);
         y_neg_ff <= ~(y0 < tr_in);
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         err_ff   <= dx_in + dy_in;
         cnt_ff   <= '0;
      end else if (cmd.emit) begin
         if (step_x) x_ff <= x_neg_ff ? x_ff - COORD_W'(1) : x_ff + COORD_W'(1);
         if (step_y) y_ff <= y_neg_ff ? y_ff - COORD_W'(1) : y_ff + COORD_W'(1);
         err_ff <= err_ff + (step_x ? dy_ff : '0) + (step_y ? dx_ff : '0);
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         point_col_ff  <= x_ff;
         point_row_ff  <= y_ff;
         col_lo_ff     <= (x_ext < rad_ext) ? '0 : COORD_W'(x_ext - rad_ext);
         row_lo_ff     <= (y_ext < rad_ext) ? '0 : COORD_W'(y_ext - rad_ext);
         col_hi_ff     <= (chi_sum > ncols_m1) ? ncols_m1[COORD_W-1:0]
                                               : chi_sum[COORD_W-1:0];
         row_hi_ff     <= (rhi_sum > nrows_m1) ? nrows_m1[COORD_W-1:0]
                                               : rhi_sum[COORD_W-1:0];
         last_point_ff <= sts.at_target;
      end
   end

   assign point_col  = point_col_ff;
   assign point_row  = point_row_ff;
   assign col_lo     = col_lo_ff;
   assign col_hi     = col_hi_ff;
   assign row_lo     = row_lo_ff;
   assign row_hi     = row_hi_ff;
   assign last_point = last_point_ff;

endmodule

// ----- rtl/brush_stroke_line_rasterizer.sv -----
// Turns pointer samples into the brush rectangles of a drawn stroke. A sample
// carries a grid cell in req_tdata and the button state in req_tuser. A pressed
// sample that continues a stroke walks a Bresenham line (any octant) from the
// last pressed cell to the new one; a pressed sample that opens a stroke visits
// only its own cell. Every visited point comes out as one rsp transfer with the
// square brush rectangle around it clamped to the grid in use, and tlast marks
// the line end. A released sample lifts the pen and yields nothing. Pointer
// cells beyond the grid are clamped to its last row and column. The block
// takes one sample at a time; a pressed sample is first set up, then its line
// points follow, produced by the single Bresenham step unit at one point a
// cycle while the output slot is free. The output register lets the next
// sample be taken while the final point still waits. Registers are written
// over the csr port, which is always ready.
module brush_stroke_line_rasterizer #(
   parameter int GRID_MAX = 64   // largest grid side, 2..64
) (
   input  logic                                clock,
   input  logic                                reset,

   // pointer samples
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bslr_pkg::REQ_TDATA_W-1:0]    req_tdata,  // pointer_col, pointer_row, pad
   input  logic [0:0]                          req_tuser,  // pressed

   // brush rectangles, one per line point
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bslr_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // point_col, point_row, col_lo,
                                                           // col_hi, row_lo, row_hi, pad
   output logic                                rsp_tlast,  // last_point

   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bslr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bslr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bslr_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   logic [COORD_W-1:0] point_col, point_row, col_lo, col_hi, row_lo, row_hi;

   // register writes never stall
   assign csr_ready = 1'b1;

   // sequencing: sample intake, line walk, output slot valid
   bslr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_pressed (req_tuser[0]),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .sts         (sts),
      .cmd         (cmd)
   );

   // registers, stroke state, line stepper and output payload
   bslr_datapath #(
      .GRID_MAX (GRID_MAX)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_write  (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_col    (req_tdata[COORD_W-1:0]),
      .req_row    (req_tdata[2*COORD_W-1:COORD_W]),
      .point_col  (point_col),
      .point_row  (point_row),
      .col_lo     (col_lo),
      .col_hi     (col_hi),
      .row_lo     (row_lo),
      .row_hi     (row_hi),
      .last_point (rsp_tlast)
   );

   // pack the result fields from the lowest bit up
   assign rsp_tdata = {(RSP_TDATA_W - 6*COORD_W)'(0),
                       row_hi, row_lo, col_hi, col_lo, point_row, point_col};

endmodule

// ----- rtl/bslr_checker.sv -----
module bslr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [0:0]                          req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [bslr_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input logic                                rsp_tlast
);

   // nothing left over from before reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tlast)))
      else $error("stalled result changed");

   // a pressed sample starts a line walk, so no further sample is taken next cycle
   a_busy_after_press: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0]) |=> !req_tready)
      else $error("sample taken during line walk");

   // a released sample produces no result
   a_release_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser[0] && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result after released sample");

endmodule

bind brush_stroke_line_rasterizer bslr_checker u_bslr_checker (.*);
